/* sv/plin_pkg.sv */
// Shared constants, codes and control types for the piecewise linear interpolator.
package plin_pkg;

  localparam int POINTS = 64;
  localparam int IDX_W  = $clog2(POINTS);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;
  localparam int DIV_W  = $clog2(DATA_W);

  typedef enum logic [1:0] {
    POS_BELOW  = 2'd0,
    POS_INTERP = 2'd1,
    POS_EXACT  = 2'd2,
    POS_ABOVE  = 2'd3
  } pos_code_t;

  typedef enum logic [1:0] {
    ACT_DONE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_INTERP  = 2'd3
  } walk_act_t;

  typedef struct packed {
    logic write;
    logic start;
    logic read;
    logic step;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
  } plin_cmd_t;

  typedef struct packed {
    walk_act_t act;
    logic      div_last;
    logic      out_free;
  } plin_status_t;

endpackage

/* sv/plin_ifs.sv */
// Item and result channel interfaces.
interface plin_item_if import plin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         point_index;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;

  modport source (output valid, mode, point_index, x_value, y_value, input ready);
  modport sink   (input valid, mode, point_index, x_value, y_value, output ready);
endinterface

interface plin_result_if import plin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_result;
  logic [IDX_W-1:0]         segment_index;
  logic [1:0]               position_code;

  modport source (output valid, y_result, segment_index, position_code, input ready);
  modport sink   (input valid, y_result, segment_index, position_code, output ready);
endinterface

/* sv/plin_ctrl.sv */
// Sequencer for table writes, segment walk, multiply and divide.
module plin_ctrl import plin_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_mode,
  output logic         item_ready,
  input  plin_status_t status,
  output plin_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_MUL, S_DINIT, S_DIV, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_mode) begin
            cmd.start  = 1'b1;
            state_next = S_READ;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.step = 1'b1;
        unique case (status.act)
          ACT_DONE:    state_next = S_DONE;
          ACT_INTERP:  state_next = S_MUL;
          ACT_RESTART: state_next = S_READ;
          ACT_ADVANCE: state_next = S_READ;
          default:     state_next = S_READ;
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/plin_dpath.sv */
// Breakpoint memories, walk registers, multiplier, divider and result register.
module plin_dpath import plin_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  plin_cmd_t         cmd,
  output plin_status_t      status,
  plin_item_if.sink         item,
  plin_result_if.source     result
);

  logic signed [DATA_W-1:0] xmem [POINTS];
  logic signed [DATA_W-1:0] ymem [POINTS];

  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         id;
  logic signed [DATA_W-1:0] xq;
  logic signed [DATA_W-1:0] xr0, xr1, yr0, yr1;
  logic [DATA_W-1:0]        num, den, mag;
  logic                     neg, interp;
  logic signed [DATA_W-1:0] y0, res_hold;
  logic [1:0]               code;
  logic [2*DATA_W-1:0]      prod;
  logic [DATA_W-1:0]        rem, quo;
  logic [DIV_W-1:0]         div_cnt;

  logic [CNT_W-1:0]         n_eff;
  logic [IDX_W-1:0]         last, id_p1;
  logic                     at_last;
  walk_act_t                act;
  logic [1:0]               done_code;
  logic signed [DATA_W:0]   dy;
  logic [DATA_W:0]          trial;
  logic signed [DATA_W-1:0] res_fin;

  always_comb begin
    if (count == '0) begin
      n_eff = CNT_W'(1);
    end else if (count > CNT_W'(POINTS)) begin
      n_eff = CNT_W'(POINTS);
    end else begin
      n_eff = count;
    end
  end

  assign last    = IDX_W'(n_eff - CNT_W'(1));
  assign id_p1   = id + IDX_W'(1);
  assign at_last = (id == last);

  // Walk decision on the entry pair just read.
  always_comb begin
    act       = ACT_DONE;
    done_code = POS_EXACT;
    if (xr0 > xq) begin
      if (id == '0) begin
        done_code = POS_BELOW;
      end else begin
        act = ACT_RESTART;
      end
    end else if (xr0 < xq) begin
      if (at_last) begin
        done_code = POS_ABOVE;
      end else if (xr1 > xq) begin
        act = ACT_INTERP;
      end else begin
        act = ACT_ADVANCE;
      end
    end else if (!at_last && xr1 == xq) begin
      act = ACT_ADVANCE;
    end
  end

  assign dy    = {yr1[DATA_W-1], yr1} - {yr0[DATA_W-1], yr0};
  assign trial = {rem, quo[DATA_W-1]} - {1'b0, den};
  assign res_fin = interp ? (neg ? y0 - $signed(quo) : y0 + $signed(quo)) : res_hold;

  assign status.act      = act;
  assign status.div_last = (div_cnt == DIV_W'(DATA_W - 1));
  assign status.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      xmem[item.point_index] <= item.x_value;
      ymem[item.point_index] <= item.y_value;
    end
    if (cmd.read) begin
      xr0 <= xmem[id];
      xr1 <= xmem[id_p1];
      yr0 <= ymem[id];
      yr1 <= ymem[id_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= CNT_W'(1);
      id           <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        count <= cfg_data;
      end
      if (cmd.write) begin
        id <= '0;
      end else if (cmd.start) begin
        if ({1'b0, id} >= n_eff) begin
          id <= '0;
        end
      end else if (cmd.step) begin
        if (act == ACT_RESTART) begin
          id <= '0;
        end else if (act == ACT_ADVANCE) begin
          id <= id_p1;
        end
      end
      if (cmd.finish) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      xq <= item.x_value;
    end
    if (cmd.step) begin
      res_hold <= yr0;
      y0       <= yr0;
      num      <= DATA_W'(xq - xr0);
      den      <= DATA_W'(xr1 - xr0);
      neg      <= dy[DATA_W];
      mag      <= dy[DATA_W] ? DATA_W'(-dy) : DATA_W'(dy);
      interp   <= (act == ACT_INTERP);
      code     <= (act == ACT_INTERP) ? POS_INTERP : done_code;
    end
    if (cmd.mul) begin
      prod <= num * mag;
    end
    // Restoring division, one quotient bit a cycle; quotient fits 32 bits.
    if (cmd.div_init) begin
      rem     <= prod[2*DATA_W-1:DATA_W];
      quo     <= prod[DATA_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_W'(1);
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      result.y_result      <= res_fin;
      result.segment_index <= id;
      result.position_code <= code;
    end
  end

endmodule

/* sv/piecewise_linear_interpolator_core.sv */
// Top level of the piecewise linear interpolator: sequencer plus datapath.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+--------------------------------------------
//  item     | in  | valid/ready    | mode, point_index, x_value, y_value
//  result   | out | valid/ready    | y_result, segment_index, position_code
//  cfg      | in  | cfg_we only    | cfg_data = point_count
//
//  A query walks the table from the cached segment, a memory read and a compare per
//  step, restarting at entry 0 at most once; an interpolated query then multiplies,
//  loads the divider and runs the 32-step restoring divider, and every query ends by
//  loading the result register. Reset sets the control idle and the point count to
//  one and clears the cached segment and result valid; the breakpoint memories hold
//  nothing until written. A result waiting on result.ready does not stop a write
//  or a new query from entering; only the next result waits for the register to free.
module piecewise_linear_interpolator_core import plin_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  plin_item_if.sink        item,
  plin_result_if.source    result,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  plin_cmd_t    cmd;
  plin_status_t status;

  // Sequence each transfer; the datapath holds all payload.
  plin_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  plin_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result loaded over a pending transfer");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.mode |=> !item.ready)
    else $error("query accepted without going busy");
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.finish))
    else $error("result valid without a finish");
`endif

endmodule

/* tb/piecewise_linear_interpolator_core_tb.sv */
// Self-checking testbench for the piecewise linear interpolator core.
module piecewise_linear_interpolator_core_tb;
  import plin_pkg::*;

  localparam bit MODE_WRITE = 1'b0;
  localparam bit MODE_QUERY = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 1400;
  // allow a margin before a register write
  localparam int WRITE_SETTLE = 4;
  localparam int DRAIN_CYCLES = 400;

  typedef enum {ROW_WRITE, ROW_QUERY, ROW_COUNT} row_kind_t;

  typedef struct {
    int               y;
    logic [IDX_W-1:0] seg;
    pos_code_t        code;
  } lookup_t;

  typedef struct {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    int               x;
    int               y;
    bit               typed;
    lookup_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  plin_item_if   item ();
  plin_result_if result ();

  piecewise_linear_interpolator_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg_we (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the core: breakpoint table, cached segment and point count.
  longint           x_tab [POINTS];
  longint           y_tab [POINTS];
  logic [IDX_W-1:0] cached_seg;
  logic [CNT_W-1:0] count_reg;

  lookup_t pending_results[$];
  int      src_idle;
  int      snk_idle;
  int      mismatches = 0;
  int      cycles = 0;
  int      items_sent;

  function automatic int unsigned points_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > POINTS) return POINTS;
    return count_reg;
  endfunction

  // y0 + (x - x0) * (y1 - y0) / (x1 - x0), exact 64-bit product, truncating division
  function automatic longint blend(longint xq, int unsigned id);
    logic [63:0] span_x;
    logic [63:0] span_full;
    logic [63:0] mag;
    logic [63:0] quot;
    longint      dy;
    span_x    = xq - x_tab[id];
    span_full = x_tab[id+1] - x_tab[id];
    dy        = y_tab[id+1] - y_tab[id];
    mag       = (dy < 0) ? -dy : dy;
    quot      = (mag * span_x) / span_full;
    return (dy < 0) ? y_tab[id] - longint'(quot) : y_tab[id] + longint'(quot);
  endfunction

  // Walk the table from the cached segment and update the cache, as the core does.
  function automatic lookup_t look_up(int xq);
    lookup_t     r;
    longint      xv;
    int unsigned n;
    int unsigned last;
    int unsigned id;
    longint      res;
    pos_code_t   code;
    xv   = xq;
    n    = points_in_use();
    last = n - 1;
    id   = (cached_seg < n) ? cached_seg : 0;
    res  = 0;
    code = POS_BELOW;
    for (int guard = 0; guard < 2 * POINTS + 2; guard++) begin
      if (x_tab[id] > xv) begin
        if (id == 0) begin
          res = y_tab[0]; code = POS_BELOW; break;
        end
        id = 0;
        continue;
      end
      if (x_tab[id] < xv) begin
        if (id == last) begin
          res = y_tab[id]; code = POS_ABOVE; break;
        end
        if (x_tab[id+1] > xv) begin
          res = blend(xv, id); code = POS_INTERP; break;
        end
        id++;
        continue;
      end
      if (id == last) begin
        res = y_tab[id]; code = POS_EXACT; break;
      end
      if (x_tab[id+1] == xv) begin
        id++;
        continue;
      end
      res = y_tab[id]; code = POS_EXACT;
      break;
    end
    cached_seg = IDX_W'(id);
    r.y    = int'(res);
    r.seg  = IDX_W'(id);
    r.code = code;
    return r;
  endfunction

  // Present one item, hold it until the transfer, then record what it should produce.
  task automatic send_item(bit mode, logic [IDX_W-1:0] idx, int x, int y,
                           bit typed = 0, lookup_t want = '{0, 0, POS_BELOW});
    lookup_t got;
    item.valid = 1'b0;
    while ($urandom_range(99) < src_idle) @(negedge clk);
    item.valid       = 1'b1;
    item.mode        = mode;
    item.point_index = idx;
    item.x_value     = x;
    item.y_value     = y;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    if (mode == MODE_WRITE) begin
      x_tab[idx] = x;
      y_tab[idx] = y;
      cached_seg = '0;
    end else begin
      got = look_up(x);
      pending_results = {pending_results, (typed ? want : got)};
    end
    items_sent++;
    @(negedge clk);
    item.valid = 1'b0;
  endtask

  // Write the point count once every result is back and the core has gone quiet.
  task automatic set_point_count(logic [CNT_W-1:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_data  = value;
    count_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load entries 0..n-1: mostly sorted with some repeated x, now and then unsorted.
  task automatic load_table(int unsigned n, output int xs[$]);
    bit narrow;
    xs.delete();
    narrow = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(7) == 0) xs = {xs, xs[i-1]};
      else if (narrow) xs = {xs, int'($urandom_range(4096)) - 2048};
      else xs = {xs, int'($urandom)};
    end
    if ($urandom_range(9) != 0) xs.sort();
    for (int i = 0; i < n; i++)
      send_item(MODE_WRITE, IDX_W'(i), xs[i],
                ($urandom_range(3) == 0) ? int'($urandom_range(255)) : int'($urandom));
  endtask

  function automatic int pick_query(const ref int xs[$]);
    int i;
    i = $urandom_range(xs.size() - 1);
    case ($urandom_range(5))
      0, 1: return xs[i];
      2, 3: return (i + 1 < xs.size()) ?
                   int'((longint'(xs[i]) + longint'(xs[i+1])) >>> 1) + $urandom_range(1)
                   : xs[i] + 1;
      4:    return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Random part: configure, load a table, query it, with a little noise mixed in.
  task automatic run_random(int target);
    int xs[$];
    int unsigned n;
    logic [CNT_W-1:0] cnt;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0: cnt = '0;
        1: cnt = CNT_W'(1);
        2: cnt = CNT_W'(2);
        3: cnt = CNT_W'(POINTS);
        4: cnt = CNT_W'($urandom_range(POINTS + 1, 127));
        default: cnt = CNT_W'($urandom_range(2, 12));
      endcase
      set_point_count(cnt);
      n = points_in_use();
      load_table(n, xs);
      repeat ($urandom_range(5, 30)) begin
        if ($urandom_range(9) == 0) begin
          // noise: rewrite some entry with any content, which also clears the cache
          send_item(MODE_WRITE, IDX_W'($urandom_range(n - 1)), int'($urandom),
                    int'($urandom));
          xs[0] = int'(x_tab[0]);
        end else begin
          send_item(MODE_QUERY, IDX_W'($urandom), pick_query(xs), int'($urandom));
        end
      end
    end
  endtask

  // Result side: stall at random and compare each transfer with the oldest expectation.
  always @(negedge clk) result.ready <= ($urandom_range(99) >= snk_idle);

  always @(posedge clk) begin
    lookup_t want;
    cycles <= cycles + 1;
    if (!rst && result.valid && result.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result y=%0d seg=%0d code=%0d", result.y_result,
                   result.segment_index, result.position_code);
      end else begin
        want = pending_results.pop_front();
        if (result.y_result !== want.y || result.segment_index !== want.seg ||
            result.position_code !== want.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y=%0d seg=%0d code=%0d, got y=%0d seg=%0d code=%0d",
                     want.y, want.seg, want.code, result.y_result,
                     result.segment_index, result.position_code);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t directed[$];

  function automatic void add_row(row_kind_t k, int idx, int x, int y,
                                  bit typed = 0, int wy = 0, int wseg = 0,
                                  pos_code_t wcode = POS_BELOW);
    row_t r;
    r.kind  = k;
    r.idx   = IDX_W'(idx);
    r.x     = x;
    r.y     = y;
    r.typed = typed;
    r.want  = '{wy, IDX_W'(wseg), wcode};
    directed = {directed, r};
  endfunction

  initial begin
    items_sent  = 0;
    cached_seg  = '0;
    count_reg   = 1;
    src_idle    = 20;
    snk_idle    = 47;
    item.valid  = 1'b0;
    item.mode   = MODE_WRITE;
    item.point_index = '0;
    item.x_value = '0;
    item.y_value = '0;
    for (int i = 0; i < POINTS; i++) begin
      x_tab[i] = 0;
      y_tab[i] = 0;
    end

    // one point in use after reset: below, exact and above that point
    add_row(ROW_WRITE, 0, 0, 32'h0001_0000);
    add_row(ROW_QUERY, 0, -1, 0, 1, 32'h0001_0000, 0, POS_BELOW);
    add_row(ROW_QUERY, 0, 0, 0, 1, 32'h0001_0000, 0, POS_EXACT);
    add_row(ROW_QUERY, 0, 32'sh7fff_ffff, 0, 1, 32'h0001_0000, 0, POS_ABOVE);
    add_row(ROW_QUERY, 63, 32'sh8000_0000, -1, 1, 32'h0001_0000, 0, POS_BELOW);
    // a count of zero acts as one
    add_row(ROW_COUNT, 0, 0, 0);
    add_row(ROW_QUERY, 0, 5, 0, 1, 32'h0001_0000, 0, POS_ABOVE);
    // four points with a repeated x and the extreme x at the top end
    add_row(ROW_WRITE, 1, 32'h0001_0000, 32'h0003_0000);
    add_row(ROW_WRITE, 2, 32'h0001_0000, -5);
    add_row(ROW_WRITE, 3, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_row(ROW_COUNT, 4, 0, 0);
    add_row(ROW_QUERY, 0, 32'h0000_8000, 0);
    add_row(ROW_QUERY, 0, 32'h0001_0000, 0);
    add_row(ROW_QUERY, 0, 32'sh7fff_ffff, 0, 1, 32'sh7fff_ffff, 3, POS_EXACT);
    // left of the cached segment: the walk restarts at entry 0
    add_row(ROW_QUERY, 0, 32'sh8000_0000, 0, 1, 32'h0001_0000, 0, POS_BELOW);
    add_row(ROW_QUERY, 0, 32'h4000_0000, 0);
    add_row(ROW_WRITE, 3, 32'sh7fff_ffff, 32'sh8000_0000);
    add_row(ROW_QUERY, 0, 32'h7000_0000, 0);
    add_row(ROW_WRITE, 0, 32'sh8000_0000, 32'sh7fff_ffff);
    add_row(ROW_QUERY, 0, 32'sh8000_0001, 0);
    add_row(ROW_QUERY, 0, 32'hffff_ffff, 0);
    // shrink the count under a high cached segment
    add_row(ROW_QUERY, 0, 32'h7fff_fffe, 0);
    add_row(ROW_COUNT, 2, 0, 0);
    add_row(ROW_QUERY, 0, 32'h0000_4000, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_WRITE: send_item(MODE_WRITE, directed[i].idx, directed[i].x, directed[i].y);
        ROW_QUERY: send_item(MODE_QUERY, directed[i].idx, directed[i].x, directed[i].y,
                             directed[i].typed, directed[i].want);
        default:   set_point_count(CNT_W'(directed[i].idx));
      endcase
    end

    // three idling regimes, each a third of the random items
    run_random(items_sent + RANDOM_ITEMS / 3);
    src_idle = 47;
    snk_idle = 20;
    run_random(items_sent + RANDOM_ITEMS / 3);
    src_idle = 0;
    snk_idle = 0;
    run_random(items_sent + RANDOM_ITEMS / 3);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/plin_pkg.sv
sv/plin_ifs.sv
sv/plin_ctrl.sv
sv/plin_dpath.sv
sv/piecewise_linear_interpolator_core.sv
tb/piecewise_linear_interpolator_core_tb.sv
